/* design/half_edge_opposite_table_builder_core_assert.svh */
// Assertion macros shared by the checker of the half-edge table builder.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HALF_EDGE_OPPOSITE_TABLE_BUILDER_CORE_ASSERT_SVH
`define HALF_EDGE_OPPOSITE_TABLE_BUILDER_CORE_ASSERT_SVH

// Implication in the same cycle.
`define HOET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hoet assertion failed");

// Implication in the next cycle.
`define HOET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hoet assertion failed");

`endif

/* design/hoet_pkg.sv */
// Shared constants for the half-edge opposite table builder.
// No dependencies.
package hoet_pkg;

  localparam int HOET_SIDES          = 3;
  localparam int HOET_MAX_VERTICES   = 1024;
  localparam int HOET_MAX_HALF_EDGES = 4096;

  localparam int IDX_W  = 12;
  localparam int VTX_W  = 10;
  localparam int CFG_W  = 11;
  localparam int ETOT_W = 13;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_RD_HE = 2'd2;
  localparam logic [1:0] ACT_RD_V  = 2'd3;

  localparam logic CFG_FACES = 1'b0;
  localparam logic CFG_VERTS = 1'b1;

endpackage

/* design/hoet_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on hoet_pkg for field widths.
interface hoet_in_if import hoet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] half_edge;
  logic [VTX_W-1:0] vertex;
  modport source (output valid, action, half_edge, vertex, input ready);
  modport sink   (input valid, action, half_edge, vertex, output ready);
endinterface

interface hoet_out_if import hoet_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  opposite;
  logic              has_opposite;
  logic [IDX_W-1:0]  edge_number;
  logic              starts_edge;
  logic [IDX_W-1:0]  vertex_half_edge;
  logic              vertex_has_half_edge;
  logic              is_manifold;
  logic [ETOT_W-1:0] edge_total;
  modport source (output valid, opposite, has_opposite, edge_number, starts_edge,
                  vertex_half_edge, vertex_has_half_edge, is_manifold, edge_total,
                  input ready);
  modport sink   (input valid, opposite, has_opposite, edge_number, starts_edge,
                  vertex_half_edge, vertex_has_half_edge, is_manifold, edge_total,
                  output ready);
endinterface

/* design/hoet_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module hoet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end
endmodule

/* design/half_edge_opposite_table_builder_core.sv */
// Top level of the half-edge opposite table builder: sequencer around five RAMs.
// Depends on hoet_pkg, hoet_if (channels) and hoet_ram.
//
//   channel | direction | handshake          | payload
//   in_s    | in        | valid/ready        | action, half_edge, vertex
//   out_m   | out       | valid/ready        | opposite .. edge_total
//   cfg_*   | in        | cfg_we only        | cfg_idx, cfg_wdata
//
// Load and read items are accepted in S_IDLE, where reads are issued, and S_RESP registers the result.
// A build runs the clear sweep over the vertices and the init sweep over the half-edges,
// then the pairing sweep, the numbering sweep and the border sweep over the half-edges;
// the pairing sweep searches up to H candidates for each unpaired half-edge, and the
// search steps are bounded by the single read port of the start-vertex RAM.
// Reset is synchronous; RAM contents are not cleared. A stalled result holds the
// block before it reports the next item; one new item may be taken meanwhile.
module half_edge_opposite_table_builder_core import hoet_pkg::*; #(
  parameter int SIDES          = HOET_SIDES,
  parameter int MAX_VERTICES   = HOET_MAX_VERTICES,
  parameter int MAX_HALF_EDGES = HOET_MAX_HALF_EDGES
) (
  input  logic             clk,
  input  logic             rst_n,
  hoet_in_if.sink          in_s,
  hoet_out_if.source       out_m,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);
  localparam int HW       = $clog2(MAX_HALF_EDGES);
  localparam int VW       = $clog2(MAX_VERTICES);
  localparam int CW       = $clog2(MAX_HALF_EDGES + 1);
  localparam int VCW      = $clog2(MAX_VERTICES + 1);
  localparam int PW       = $clog2(SIDES);
  localparam int FACE_CAP = MAX_HALF_EDGES / SIDES;
  localparam int EW       = IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP,
    B_CLR, B_INIT_RD, B_INIT_WR,
    M_RDOPP, M_CHK, M_A, M_B, M_KRD, M_KCMP, M_GCMP, M_WR2,
    N_RD, N_CHK, N_WR2,
    D_RD, D_CHK, D_VH, D_CUR
  } state_t;

  state_t state_r;

  // configuration and result state
  logic [CFG_W-1:0]  face_count_r, vertex_count_r;
  logic              manifold_r;
  logic [ETOT_W-1:0] edge_cnt_r;

  // item context
  logic [1:0]        act_r;
  logic              inrange_r;

  // build sequencer registers
  logic [CW-1:0]     nh_r, h_r, k_r, g_r;
  logic [VCW-1:0]    nv_r;
  logic [PW-1:0]     hp_r, kp_r;
  logic [VTX_W-1:0]  a_r, b_r, v_r;
  logic [IDX_W-1:0]  cur_r, o_r;
  logic [ETOT_W-1:0] e_r;

  // output register
  logic              out_valid_r;
  logic [IDX_W-1:0]  o_opp_r, o_en_r, o_vhe_r;
  logic              o_hasopp_r, o_se_r, o_vhas_r;
  logic              o_man_r;
  logic [ETOT_W-1:0] o_etot_r;

  // RAM ports
  logic              sv_we, sv_re, op_we, op_re, en_we, es_we, es_re, vh_we, vh_re, en_re;
  logic [HW-1:0]     sv_wa, sv_ra, op_wa, op_ra, en_wa, en_ra, es_wa, es_ra;
  logic [VW-1:0]     vh_wa, vh_ra;
  logic [VTX_W-1:0]  sv_wd, sv_rd;
  logic [EW-1:0]     op_wd, op_rd, vh_wd, vh_rd;
  logic [IDX_W-1:0]  en_wd, en_rd;
  logic              es_wd, es_rd;

  logic              in_acc, out_free;
  logic [CW-1:0]     h_succ, k_pred, h_inc, k_inc;
  logic [PW-1:0]     hp_inc, kp_inc;

  assign in_s.ready = (state_r == S_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_r || out_m.ready;

  // walk positions inside a face without a divider
  assign h_succ = (hp_r == PW'(SIDES - 1)) ? h_r - CW'(SIDES - 1) : h_r + CW'(1);
  assign k_pred = (kp_r == '0) ? k_r + CW'(SIDES - 1) : k_r - CW'(1);
  assign h_inc  = h_r + CW'(1);
  assign k_inc  = k_r + CW'(1);
  assign hp_inc = (hp_r == PW'(SIDES - 1)) ? '0 : hp_r + PW'(1);
  assign kp_inc = (kp_r == PW'(SIDES - 1)) ? '0 : kp_r + PW'(1);

  hoet_ram #(.WIDTH(VTX_W), .DEPTH(MAX_HALF_EDGES)) u_sv (
    .clk, .we(sv_we), .wa(sv_wa), .wd(sv_wd), .re(sv_re), .ra(sv_ra), .rd(sv_rd));
  hoet_ram #(.WIDTH(EW), .DEPTH(MAX_HALF_EDGES)) u_op (
    .clk, .we(op_we), .wa(op_wa), .wd(op_wd), .re(op_re), .ra(op_ra), .rd(op_rd));
  hoet_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HALF_EDGES)) u_en (
    .clk, .we(en_we), .wa(en_wa), .wd(en_wd), .re(en_re), .ra(en_ra), .rd(en_rd));
  hoet_ram #(.WIDTH(1), .DEPTH(MAX_HALF_EDGES)) u_es (
    .clk, .we(es_we), .wa(es_wa), .wd(es_wd), .re(es_re), .ra(es_ra), .rd(es_rd));
  hoet_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_vh (
    .clk, .we(vh_we), .wa(vh_wa), .wd(vh_wd), .re(vh_re), .ra(vh_ra), .rd(vh_rd));

  // RAM control per sequencer state
  always_comb begin
    sv_we = 1'b0; sv_wa = '0; sv_wd = '0; sv_re = 1'b0; sv_ra = '0;
    op_we = 1'b0; op_wa = '0; op_wd = '0; op_re = 1'b0; op_ra = '0;
    en_we = 1'b0; en_wa = '0; en_wd = '0; en_re = 1'b0; en_ra = '0;
    es_we = 1'b0; es_wa = '0; es_wd = 1'b0; es_re = 1'b0; es_ra = '0;
    vh_we = 1'b0; vh_wa = '0; vh_wd = '0; vh_re = 1'b0; vh_ra = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && 32'(in_s.half_edge) < MAX_HALF_EDGES) begin
          sv_we = (in_s.action == ACT_LOAD);
          sv_wa = HW'(in_s.half_edge);
          sv_wd = in_s.vertex;
          op_re = (in_s.action == ACT_RD_HE);
          en_re = op_re;
          es_re = op_re;
          op_ra = HW'(in_s.half_edge);
          en_ra = op_ra;
          es_ra = op_ra;
        end
        if (in_acc && 32'(in_s.vertex) < MAX_VERTICES) begin
          vh_re = (in_s.action == ACT_RD_V);
          vh_ra = VW'(in_s.vertex);
        end
      end
      B_CLR: begin
        vh_we = (32'(h_r) < 32'(nv_r));
        vh_wa = VW'(h_r);
      end
      B_INIT_RD: begin
        sv_re = (h_r < nh_r);
        sv_ra = HW'(h_r);
      end
      B_INIT_WR: begin
        vh_we = (32'(sv_rd) < 32'(nv_r));
        vh_wa = VW'(sv_rd);
        vh_wd = {1'b1, IDX_W'(h_r)};
        op_we = 1'b1;
        op_wa = HW'(h_r);
        es_we = 1'b1;
        es_wa = HW'(h_r);
      end
      M_RDOPP: begin
        op_re = (h_r < nh_r);
        op_ra = HW'(h_r);
      end
      M_CHK: begin
        es_we = !op_rd[IDX_W];
        es_wa = HW'(h_r);
        es_wd = 1'b1;
        sv_re = !op_rd[IDX_W];
        sv_ra = HW'(h_r);
      end
      M_A: begin
        sv_re = 1'b1;
        sv_ra = HW'(h_succ);
      end
      M_KRD: begin
        sv_re = (k_r < nh_r);
        sv_ra = HW'(k_r);
      end
      M_KCMP: begin
        sv_re = (sv_rd == a_r);
        sv_ra = HW'(k_pred);
        op_re = sv_re;
        op_ra = HW'(k_pred);
      end
      M_GCMP: begin
        op_we = (sv_rd == b_r) && !op_rd[IDX_W];
        op_wa = HW'(h_r);
        op_wd = {1'b1, IDX_W'(g_r)};
      end
      M_WR2: begin
        op_we = 1'b1;
        op_wa = HW'(g_r);
        op_wd = {1'b1, IDX_W'(h_r)};
      end
      N_RD: begin
        es_re = (h_r < nh_r);
        es_ra = HW'(h_r);
        op_re = es_re;
        op_ra = HW'(h_r);
      end
      N_CHK: begin
        en_we = es_rd;
        en_wa = HW'(h_r);
        en_wd = IDX_W'(e_r);
      end
      N_WR2: begin
        en_we = 1'b1;
        en_wa = HW'(o_r);
        en_wd = IDX_W'(e_r);
      end
      D_RD: begin
        sv_re = (h_r < nh_r);
        sv_ra = HW'(h_r);
        op_re = sv_re;
        op_ra = HW'(h_r);
      end
      D_CHK: begin
        vh_re = (32'(sv_rd) < 32'(nv_r)) && !op_rd[IDX_W];
        vh_ra = VW'(sv_rd);
      end
      D_VH: begin
        op_re = vh_rd[IDX_W] && (32'(vh_rd[IDX_W-1:0]) < MAX_HALF_EDGES);
        op_ra = HW'(vh_rd[IDX_W-1:0]);
        // entry points past the table: take this border half-edge
        vh_we = vh_rd[IDX_W] && !(32'(vh_rd[IDX_W-1:0]) < MAX_HALF_EDGES);
        vh_wa = VW'(v_r);
        vh_wd = {1'b1, IDX_W'(h_r)};
      end
      D_CUR: begin
        vh_we = 1'b1;
        vh_wa = VW'(v_r);
        vh_wd = (!op_rd[IDX_W] && 32'(cur_r) != 32'(h_r)) ? '0 : {1'b1, IDX_W'(h_r)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      face_count_r   <= '0;
      vertex_count_r <= '0;
      manifold_r     <= 1'b1;
      edge_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_FACES) begin
        face_count_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == CFG_VERTS) begin
        vertex_count_r <= cfg_wdata;
      end
      // drop the result once taken; S_RESP reloads it on its own
      if (out_valid_r && out_m.ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r     <= in_s.action;
            inrange_r <= (in_s.action == ACT_RD_V) ? (32'(in_s.vertex) < MAX_VERTICES)
                                                   : (32'(in_s.half_edge) < MAX_HALF_EDGES);
            if (in_s.action == ACT_BUILD) begin
              // cap the face count to the table, then start the clear sweep
              nh_r <= CW'(((32'(face_count_r) > FACE_CAP) ? FACE_CAP
                                                           : 32'(face_count_r)) * SIDES);
              nv_r <= VCW'((32'(vertex_count_r) > MAX_VERTICES) ? MAX_VERTICES
                                                                : 32'(vertex_count_r));
              manifold_r <= 1'b1;
              edge_cnt_r <= '0;
              h_r        <= '0;
              state_r    <= B_CLR;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_opp_r     <= '0;
            o_hasopp_r  <= 1'b0;
            o_en_r      <= '0;
            o_se_r      <= 1'b0;
            o_vhe_r     <= '0;
            o_vhas_r    <= 1'b0;
            // hold the build summary with the result so a later build can't alter it
            o_man_r     <= manifold_r;
            o_etot_r    <= edge_cnt_r;
            if (inrange_r && act_r == ACT_RD_HE) begin
              o_opp_r    <= op_rd[IDX_W-1:0];
              o_hasopp_r <= op_rd[IDX_W];
              o_en_r     <= en_rd;
              o_se_r     <= es_rd;
            end
            if (inrange_r && act_r == ACT_RD_V) begin
              o_vhe_r  <= vh_rd[IDX_W-1:0];
              o_vhas_r <= vh_rd[IDX_W];
            end
            state_r <= S_IDLE;
          end
        end
        B_CLR: begin
          if (32'(h_r) < 32'(nv_r)) begin
            h_r <= h_inc;
          end else begin
            h_r     <= '0;
            state_r <= B_INIT_RD;
          end
        end
        B_INIT_RD: begin
          if (h_r < nh_r) begin
            state_r <= B_INIT_WR;
          end else begin
            h_r     <= '0;
            hp_r    <= '0;
            state_r <= M_RDOPP;
          end
        end
        B_INIT_WR: begin
          h_r     <= h_inc;
          state_r <= B_INIT_RD;
        end
        M_RDOPP: begin
          if (h_r < nh_r) begin
            state_r <= M_CHK;
          end else begin
            h_r     <= '0;
            e_r     <= '0;
            state_r <= N_RD;
          end
        end
        M_CHK: begin
          if (op_rd[IDX_W]) begin
            h_r     <= h_inc;
            hp_r    <= hp_inc;
            state_r <= M_RDOPP;
          end else begin
            state_r <= M_A;
          end
        end
        M_A: begin
          a_r     <= sv_rd;
          state_r <= M_B;
        end
        M_B: begin
          b_r     <= sv_rd;
          k_r     <= '0;
          kp_r    <= '0;
          state_r <= M_KRD;
        end
        M_KRD: begin
          if (k_r < nh_r) begin
            state_r <= M_KCMP;
          end else begin
            // no partner: border half-edge
            h_r     <= h_inc;
            hp_r    <= hp_inc;
            state_r <= M_RDOPP;
          end
        end
        M_KCMP: begin
          if (sv_rd == a_r) begin
            g_r     <= k_pred;
            state_r <= M_GCMP;
          end else begin
            k_r     <= k_inc;
            kp_r    <= kp_inc;
            state_r <= M_KRD;
          end
        end
        M_GCMP: begin
          if (sv_rd == b_r && !op_rd[IDX_W]) begin
            state_r <= M_WR2;
          end else begin
            k_r     <= k_inc;
            kp_r    <= kp_inc;
            state_r <= M_KRD;
          end
        end
        M_WR2: begin
          h_r     <= h_inc;
          hp_r    <= hp_inc;
          state_r <= M_RDOPP;
        end
        N_RD: begin
          if (h_r < nh_r) begin
            state_r <= N_CHK;
          end else begin
            edge_cnt_r <= e_r;
            h_r        <= '0;
            state_r    <= D_RD;
          end
        end
        N_CHK: begin
          if (es_rd && op_rd[IDX_W] && 32'(op_rd[IDX_W-1:0]) < MAX_HALF_EDGES) begin
            o_r     <= op_rd[IDX_W-1:0];
            state_r <= N_WR2;
          end else begin
            if (es_rd) begin
              e_r <= e_r + ETOT_W'(1);
            end
            h_r     <= h_inc;
            state_r <= N_RD;
          end
        end
        N_WR2: begin
          e_r     <= e_r + ETOT_W'(1);
          h_r     <= h_inc;
          state_r <= N_RD;
        end
        D_RD: begin
          state_r <= (h_r < nh_r) ? D_CHK : S_RESP;
        end
        D_CHK: begin
          if (32'(sv_rd) < 32'(nv_r) && !op_rd[IDX_W]) begin
            v_r     <= sv_rd;
            state_r <= D_VH;
          end else begin
            h_r     <= h_inc;
            state_r <= D_RD;
          end
        end
        D_VH: begin
          if (vh_rd[IDX_W] && 32'(vh_rd[IDX_W-1:0]) < MAX_HALF_EDGES) begin
            cur_r   <= vh_rd[IDX_W-1:0];
            state_r <= D_CUR;
          end else begin
            h_r     <= h_inc;
            state_r <= D_RD;
          end
        end
        D_CUR: begin
          // two border half-edges leave this vertex: drop the entry
          if (!op_rd[IDX_W] && 32'(cur_r) != 32'(h_r)) begin
            manifold_r <= 1'b0;
          end
          h_r     <= h_inc;
          state_r <= D_RD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_m.valid                = out_valid_r;
  assign out_m.opposite             = o_opp_r;
  assign out_m.has_opposite         = o_hasopp_r;
  assign out_m.edge_number          = o_en_r;
  assign out_m.starts_edge          = o_se_r;
  assign out_m.vertex_half_edge     = o_vhe_r;
  assign out_m.vertex_has_half_edge = o_vhas_r;
  assign out_m.is_manifold          = o_man_r;
  assign out_m.edge_total           = o_etot_r;
endmodule

/* design/hoet_checker.sv */
// Port-level checker for the half-edge table builder, bound to the top level.
// Depends on half_edge_opposite_table_builder_core_assert.svh.
`include "half_edge_opposite_table_builder_core_assert.svh"

module hoet_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  logic [1:0] pend_r;
  logic       acc, dlv;

  assign acc = in_valid && in_ready;
  assign dlv = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (acc && !dlv) begin
      pend_r <= pend_r + 2'd1;
    end else if (dlv && !acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  `HOET_ASSERT_NOW(a_no_orphan_result, out_valid, pend_r != 2'd0)
  `HOET_ASSERT_NOW(a_pend_bound, 1'b1, pend_r != 2'd3)
  `HOET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind half_edge_opposite_table_builder_core hoet_checker u_hoet_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_s.valid),
  .in_ready(in_s.ready),
  .out_valid(out_m.valid),
  .out_ready(out_m.ready)
);
